### hdl/kmd_pkg.sv
// shared types, constants and key placement functions for the key matrix debouncer
`timescale 1ns / 1ps

package kmd_pkg;

	// fixed field widths
	localparam int MAX_KEYS    = 11;
	localparam int CELL_W      = 12;
	localparam int TIME_W      = 32;
	localparam int DEB_W       = 8;
	localparam int CELL_STRIDE = 4;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 48;

	// debounce hold time after reset
	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd20;

	// what one key lane reports for one scan
	typedef struct packed {
		logic press;
		logic release_edge;
		logic stable;
		logic raw;
	} kmd_lane_res_t;

	typedef kmd_lane_res_t [MAX_KEYS-1:0] kmd_lane_vec_t;

	// matrix row of key index k (zero based)
	function automatic int key_row(input int k);
		int r;
		r = 0;
		if (k < 3) begin
			r = 0;
		end else if (k < 7) begin
			r = 1;
		end else begin
			r = 2;
		end
		return r;
	endfunction

	// matrix column of key index k (zero based)
	function automatic int key_col(input int k);
		int c;
		c = 0;
		if (k < 3) begin
			c = k;
		end else if (k < 7) begin
			c = k - 3;
		end else begin
			c = k - 7;
		end
		return c;
	endfunction

endpackage

### hdl/kmd_lane.sv
// one key lane: four-phase debouncer with its own phase start time
`timescale 1ns / 1ps

module kmd_lane #(
	parameter int KEY_IDX   = 0,
	parameter int ROW_COUNT = 3,
	parameter int COL_COUNT = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [kmd_pkg::CELL_W-1:0]    cell_levels,
	input  logic [kmd_pkg::TIME_W-1:0]    now_ms,
	input  logic [kmd_pkg::DEB_W-1:0]     debounce_ms,
	output kmd_pkg::kmd_lane_res_t        res
);
	import kmd_pkg::*;

	localparam int ROW  = key_row(KEY_IDX);
	localparam int COL  = key_col(KEY_IDX);
	localparam bit LIVE = (ROW < ROW_COUNT) && (COL < COL_COUNT);
	localparam int CELL = ROW * CELL_STRIDE + COL;

	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_DEB_PRESS   = 2'd1,
		PH_PRESSED     = 2'd2,
		PH_DEB_RELEASE = 2'd3
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [TIME_W-1:0]   start_q, start_d;
	logic [TIME_W-1:0]   elapsed;
	logic                lvl;
	logic                held;
	logic                press_d, release_d;

	// cell sample for this key
	assign lvl = LIVE ? cell_levels[CELL] : 1'b0;

	// wrapping elapsed time against the hold time
	assign elapsed = now_ms - start_q;
	assign held    = elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_ms};

	// next phase and edge detection
	always_comb begin
		phase_d   = phase_q;
		start_d   = start_q;
		press_d   = 1'b0;
		release_d = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (lvl) begin
					phase_d = PH_DEB_PRESS;
					start_d = now_ms;
				end
			end
			PH_DEB_PRESS: begin
				if (!lvl) begin
					phase_d = PH_IDLE;
				end else if (held) begin
					phase_d = PH_PRESSED;
					press_d = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (!lvl) begin
					phase_d = PH_DEB_RELEASE;
					start_d = now_ms;
				end
			end
			PH_DEB_RELEASE: begin
				if (lvl) begin
					phase_d = PH_PRESSED;
				end else if (held) begin
					phase_d   = PH_IDLE;
					release_d = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// lane result for the merge stage
	always_comb begin
		res.press        = press_d;
		res.release_edge = release_d;
		res.stable       = (phase_d == PH_PRESSED) || (phase_d == PH_DEB_RELEASE);
		res.raw          = lvl;
	end

	// phase and start time advance on each accepted scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			start_q <= start_d;
		end
	end

endmodule

### hdl/kmd_merge.sv
// merge stage: gathers lane results into one output beat and holds it for the receiver
`timescale 1ns / 1ps

module kmd_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  kmd_pkg::kmd_lane_vec_t            lane_res,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [kmd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import kmd_pkg::*;

	logic [MAX_KEYS-1:0]   press_v, release_v, stable_v, raw_v;
	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;

	// split lane results into per-field masks
	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			press_v[i]   = lane_res[i].press;
			release_v[i] = lane_res[i].release_edge;
			stable_v[i]  = lane_res[i].stable;
			raw_v[i]     = lane_res[i].raw;
		end
	end

	// take a new beat when the register is empty or being drained
	assign in_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload, packed from the lowest bit up
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= {{(OUT_DATA_W - 4*MAX_KEYS){1'b0}}, raw_v, stable_v, release_v, press_v};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

`ifndef SYNTH
	// a key never reports a press and a release in the same scan
	a_no_dual_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[10:0] & m_axis_tdata[21:11]) == 11'd0))
		else $error("press and release edge on the same key");

	// a press edge leaves the key stable pressed
	a_press_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[10:0] & ~m_axis_tdata[32:22]) == 11'd0))
		else $error("press edge without stable pressed state");

	// a release edge leaves the key stable released
	a_release_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[21:11] & m_axis_tdata[32:22]) == 11'd0))
		else $error("release edge with stable pressed state");

	// an accepted scan shows up as an output beat in the next cycle
	a_accept_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> m_axis_tvalid)
		else $error("accepted scan produced no output beat");
`endif

endmodule

### hdl/key_matrix_debouncer_top.sv
// top level of the key matrix debouncer: config register, key lanes and merge stage
`timescale 1ns / 1ps

// Key matrix debouncer.
// s_axis carries one full matrix scan per beat: the 12 cell levels and a
// wrapping millisecond timestamp. m_axis returns one beat per scan with the
// per-key press edges, release edges, debounced state and raw levels.
// Each key has its own lane holding its debounce phase and phase start time;
// all lanes work on the same scan in parallel and a merge stage registers
// their combined result.
// An accepted scan appears as its output beat in the next cycle. Throughput
// is one scan per cycle, set by the single output register; s_axis_tready
// stays high while that register is empty or being taken the same cycle.
// When the receiver stalls, the output beat holds and the block takes no new
// scan until that beat is taken.
// cfg_we writes cfg_wdata as the debounce time in ms; write it only while idle.
// Reset puts every key in the idle phase, clears the start times, empties the
// output register and sets the debounce time to 20 ms.

module key_matrix_debouncer_top #(
	parameter int KEY_COUNT = 11,
	parameter int ROW_COUNT = 3,
	parameter int COL_COUNT = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// scan input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [11:0] cell_levels, [43:12] now_ms, [47:44] zero
	input  logic [kmd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// key result output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [10:0] press_edges, [21:11] release_edges, [32:22] stable_keys,
	// [43:33] raw_keys, [47:44] zero
	output logic [kmd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// debounce time register
	input  logic                              cfg_we,
	input  logic [kmd_pkg::DEB_W-1:0]         cfg_wdata
);
	import kmd_pkg::*;

	logic [DEB_W-1:0]  debounce_ms_q;
	logic [CELL_W-1:0] cell_levels;
	logic [TIME_W-1:0] now_ms;
	logic              advance;
	kmd_lane_vec_t     lane_res;

	// unpack the scan beat
	assign cell_levels = s_axis_tdata[CELL_W-1:0];
	assign now_ms      = s_axis_tdata[CELL_W +: TIME_W];
	assign advance     = s_axis_tvalid && s_axis_tready;

	// debounce time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_ms_q <= cfg_wdata;
		end
	end

	// one lane per key, keys past the count report nothing
	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_lane
		if (i < KEY_COUNT) begin : g_live
			kmd_lane #(
				.KEY_IDX   (i),
				.ROW_COUNT (ROW_COUNT),
				.COL_COUNT (COL_COUNT)
			) u_lane (
				.clk         (clk),
				.arst_n      (arst_n),
				.advance     (advance),
				.cell_levels (cell_levels),
				.now_ms      (now_ms),
				.debounce_ms (debounce_ms_q),
				.res         (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = '0;
		end
	end

	// merge lanes into the output beat
	kmd_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.lane_res      (lane_res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
